// File: src/assert_macros.svh
// Assertion macros used by the replacement policy datapath.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: src/lfu_pkg.sv
// Shared types and constants for the LFU replacement policy block.
// No dependencies; imported by lfu_ctrl, lfu_datapath and the top module.
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int STAMP_BITS_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT,
        CMD_ACCESS,
        CMD_EVICT_LEAST,
        CMD_EVICT_SLOT
    } t_cmd_code;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_EMPTY,
        ST_BAD_SLOT
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_SCAN,
        S_SCAN_END,
        S_EVICT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic clr_wr;
        logic scan_start;
        logic scan_rd;
        logic upd_wr;
        logic evict_wr;
        logic res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_last;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: src/lfu_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: src/lfu_ctrl.sv
// Controller state machine for the LFU replacement policy block.
// Depends on lfu_pkg; drives the datapath through t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module lfu_ctrl
    import lfu_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [CMD_W-1:0]     i_cmd,
    input  wire t_dp_sts              i_sts,
    output logic                      o_ready,
    output t_dp_cmd                   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in    = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    if (t_cmd_code'(i_cmd) == CMD_EVICT_LEAST) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.upd_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_EVICT;
            end
            S_EVICT: begin
                o_cmd.evict_wr = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!i_sts.out_busy) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/lfu_datapath.sv
// Datapath of the LFU replacement policy: slot table RAM, stamp counter,
// minimum scan and output register. Depends on lfu_pkg, lfu_ram and the macros.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lfu_datapath
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    input  wire logic [CMD_W-1:0]     i_in_cmd,
    input  wire logic [SLOT_W-1:0]    i_slot,
    input  wire logic                 i_ready,
    output t_dp_sts                   o_sts,
    output logic                      o_valid,
    output logic [STATUS_W-1:0]       o_status,
    output logic [SLOT_W-1:0]         o_victim,
    output logic                      o_victim_valid
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int W     = 1 + COUNT_BITS + STAMP_BITS;

    t_cmd_code             r_cmd;
    logic [SLOT_W-1:0]     r_slot;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_found;
    logic [IDX_W-1:0]      r_best_idx;
    logic [COUNT_BITS-1:0] r_best_cnt;
    logic [STAMP_BITS-1:0] r_best_st;
    logic [STAMP_BITS-1:0] r_stamp;
    logic [STAMP_BITS-1:0] n_stamp;
    t_status               r_res_status;
    t_status               n_res_status;
    logic [SLOT_W-1:0]     r_res_victim;
    logic [SLOT_W-1:0]     n_res_victim;
    logic                  r_res_vv;
    logic                  n_res_vv;
    logic                  r_out_vld;
    logic [STATUS_W-1:0]   r_out_status;
    logic [SLOT_W-1:0]     r_out_victim;
    logic                  r_out_vv;

    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [W-1:0]          wdata;
    logic [IDX_W-1:0]      raddr;
    logic [W-1:0]          rdata;
    logic                  rd_v;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [STAMP_BITS-1:0] rd_st;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  in_range;
    logic                  take;

    lfu_ram #(
        .WIDTH (W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_v     = rdata[W-1];
    assign rd_cnt   = rdata[W-2 -: COUNT_BITS];
    assign rd_st    = rdata[STAMP_BITS-1:0];
    assign cnt_inc  = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
    assign in_range = int'(r_slot) < ENTRIES;
    assign raddr    = i_cmd.scan_rd ? r_idx : IDX_W'(r_slot);

    assign take = r_cmp_vld && rd_v &&
                  (!r_found || (rd_cnt < r_best_cnt) ||
                   ((rd_cnt == r_best_cnt) && (rd_st > r_best_st)));

    assign o_sts.idx_last = (r_idx == IDX_W'(ENTRIES - 1));
    assign o_sts.out_busy = r_out_vld && !i_ready;

    always_comb begin
        we           = 1'b0;
        waddr        = r_idx;
        wdata        = '0;
        n_stamp      = r_stamp;
        n_res_status = r_res_status;
        n_res_victim = r_res_victim;
        n_res_vv     = r_res_vv;
        if (i_cmd.clr_wr) begin
            we = 1'b1;
        end
        if (i_cmd.upd_wr) begin
            waddr        = IDX_W'(r_slot);
            n_res_status = ST_OK;
            n_res_victim = '0;
            n_res_vv     = 1'b0;
            unique case (r_cmd)
                CMD_INSERT: begin
                    if (in_range) begin
                        we      = 1'b1;
                        wdata   = {1'b1, COUNT_BITS'(1), r_stamp};
                        n_stamp = r_stamp + STAMP_BITS'(1);
                    end else begin
                        n_res_status = ST_BAD_SLOT;
                    end
                end
                CMD_ACCESS: begin
                    if (in_range && rd_v) begin
                        we      = 1'b1;
                        wdata   = {1'b1, cnt_inc, r_stamp};
                        n_stamp = r_stamp + STAMP_BITS'(1);
                    end else begin
                        n_res_status = ST_BAD_SLOT;
                    end
                end
                CMD_EVICT_SLOT: begin
                    if (in_range && rd_v) begin
                        we           = 1'b1;
                        n_res_victim = r_slot;
                        n_res_vv     = 1'b1;
                    end else begin
                        n_res_status = ST_BAD_SLOT;
                    end
                end
                CMD_EVICT_LEAST: begin
                    n_res_status = ST_EMPTY;
                end
            endcase
        end
        if (i_cmd.evict_wr) begin
            if (r_found) begin
                we           = 1'b1;
                waddr        = r_best_idx;
                n_res_status = ST_OK;
                n_res_victim = SLOT_W'(r_best_idx);
                n_res_vv     = 1'b1;
            end else begin
                n_res_status = ST_EMPTY;
                n_res_victim = '0;
                n_res_vv     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_stamp      <= '0;
            r_out_vld    <= 1'b0;
            r_res_status <= ST_OK;
            r_res_vv     <= 1'b0;
        end else begin
            r_cmp_vld    <= i_cmd.scan_rd;
            r_stamp      <= n_stamp;
            r_res_status <= n_res_status;
            r_res_vv     <= n_res_vv;
            if (i_cmd.scan_start) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.clr_wr || i_cmd.scan_rd) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.res_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_victim <= n_res_victim;
        r_cmp_idx    <= r_idx;
        if (i_cmd.load_in) begin
            r_cmd  <= t_cmd_code'(i_in_cmd);
            r_slot <= i_slot;
        end
        if (take) begin
            r_best_idx <= r_cmp_idx;
            r_best_cnt <= rd_cnt;
            r_best_st  <= rd_st;
        end
        if (i_cmd.res_load) begin
            r_out_status <= r_res_status;
            r_out_victim <= r_res_victim;
            r_out_vv     <= r_res_vv;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_status       = r_out_status;
    assign o_victim       = r_out_victim;
    assign o_victim_valid = r_out_vv;

    `ASSERT_IMPLIES(a_found_count_nonzero, i_clk, i_rst_n, r_found && !r_cmp_vld, r_best_cnt != '0)
    `ASSERT_IMPLIES(a_load_after_scan, i_clk, i_rst_n, i_cmd.res_load, !r_cmp_vld)
    `ASSERT_IMPLIES(a_victim_ok, i_clk, i_rst_n, i_cmd.res_load && r_res_vv, r_res_status == ST_OK)
    `ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, i_cmd.res_load, r_out_vld)

endmodule

`default_nettype wire

// File: src/lfu_replacement_policy_top.sv
// LFU replacement policy over ENTRIES cache slots, addressed by slot index.
// Input channel i_valid/o_ready carries i_cmd (insert, access, evict least,
// evict named slot) and i_slot. Output channel o_valid/i_ready carries
// o_status, o_victim and o_victim_valid, one result per input transfer.
// Insert, access and evict named slot pass through S_READ, S_UPDATE and
// S_DONE after the input transfer; evict least passes through S_SCAN,
// which reads the slot table RAM one entry per cycle through its single read
// port, then S_SCAN_END, S_EVICT and S_DONE. o_ready returns in the cycle
// after the result is loaded into the output register.
// One item is in work at a time; a new item is taken while the previous
// result still waits in the output register.
// After reset a clearing pass writes every RAM entry to zero, one per cycle,
// so o_ready stays low until that pass ends; the stamp counter restarts at zero.
// When the receiver stalls, the result holds in the output register and a
// finished item waits until that register is free.
// Depends on lfu_pkg, lfu_ctrl, lfu_datapath and lfu_ram.
`timescale 1ns / 1ps
`default_nettype none

module lfu_replacement_policy_top
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [CMD_W-1:0]     i_cmd,
    input  wire logic [SLOT_W-1:0]    i_slot,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [STATUS_W-1:0]       o_status,
    output logic [SLOT_W-1:0]         o_victim,
    output logic                      o_victim_valid
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    lfu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_sts   (dp_sts),
        .o_ready (o_ready),
        .o_cmd   (dp_cmd)
    );

    lfu_datapath #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_in_cmd       (i_cmd),
        .i_slot         (i_slot),
        .i_ready        (i_ready),
        .o_sts          (dp_sts),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_victim       (o_victim),
        .o_victim_valid (o_victim_valid)
    );

endmodule

`default_nettype wire
